// ----- rtl/core/bpa_pkg.sv -----
package bpa_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int ORDERS    = 11;
  localparam int PAGE_W    = 12;
  localparam int LINK_W    = 13;
  localparam int ORD_W     = 4;
  localparam int CNT_W     = 13;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ADD   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_PHANTOM = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_USED    = 2'd2,
    KIND_INNER   = 2'd3
  } page_kind_t;

  typedef struct packed {
    page_kind_t        kind;
    logic [ORD_W-1:0]  mark;
    logic [LINK_W-1:0] link;
    logic [ORDERS-1:0] hint;
  } page_row_t;

  typedef struct packed {
    logic kind;
    logic mark;
    logic link;
    logic hint;
  } row_mask_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_SPLIT,
    S_FREE_RD,
    S_MERGE_CHK,
    S_MERGE_RD,
    S_WALK,
    S_WALK_RD,
    S_UNLINK_PREV,
    S_UNLINK_BLK,
    S_SCAN,
    S_CARVE,
    S_FILL,
    S_PUSH_ROW,
    S_PUSH_LINK,
    S_DONE
  } fsm_t;

endpackage

// ----- rtl/core/buddy_page_allocator_unit.sv -----
// Buddy page allocator over 4096 pages with one FIFO free list per order
// (0..10). All per-page state lives in one synchronous page memory; list
// heads and tails sit in registers. After reset the block sweeps the page
// memory once and accepts no command until that is done. One command is
// handled at a time and its cost depends on the memory traffic. An allocate
// reads the head block, marks it used and pushes one upper half per split. A
// free reads the block and, per merge step, reads the buddy, walks its free
// list to the buddy's predecessor and unlinks it. An add range scans each
// page, writes each inner page and pushes each block. Each command gives
// exactly one result; the next command may be taken while a result waits on
// the output.
module buddy_page_allocator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic [3:0]                 order,
  input  logic [bpa_pkg::PAGE_W-1:0] pfn,
  input  logic [bpa_pkg::CNT_W-1:0]  range_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [bpa_pkg::PAGE_W-1:0] block_pfn,
  output logic [bpa_pkg::CNT_W-1:0]  pages_added,
  output logic [bpa_pkg::CNT_W-1:0]  used_pages,
  output logic [bpa_pkg::CNT_W-1:0]  total_pages
);
  import bpa_pkg::*;

  // page memory
  page_row_t page_mem [NUM_PAGES];
  page_row_t rd_q;
  logic              rd_en;
  logic [PAGE_W-1:0] rd_addr;
  logic              wr_en;
  logic [PAGE_W-1:0] wr_addr;
  row_mask_t         wr_mask;
  page_row_t         wr_row;

  // control and working registers
  fsm_t state, state_next, ret_state, ret_state_next;
  logic [PAGE_W-1:0] clr, clr_next;
  logic [LINK_W-1:0] heads [ORDERS];
  logic [LINK_W-1:0] heads_next [ORDERS];
  logic [LINK_W-1:0] tails [ORDERS];
  logic [LINK_W-1:0] tails_next [ORDERS];
  logic [CNT_W-1:0]  used_cnt, used_cnt_next, total_cnt, total_cnt_next;
  logic [ORD_W-1:0]  ord_q, ord_q_next, j, j_next, co, co_next, po, po_next;
  logic [ORD_W-1:0]  ck_q, ck_q_next;
  logic [PAGE_W-1:0] p_q, p_q_next, pp, pp_next, b_q, b_q_next;
  logic [LINK_W-1:0] b_link, b_link_next, prev, prev_next, wp, wp_next;
  logic [LINK_W-1:0] ptail, ptail_next;
  logic [CNT_W-1:0]  lo, lo_next, hi_q, hi_q_next, fill, fill_next;
  logic [1:0]        res_status, res_status_next;
  logic [PAGE_W-1:0] res_blk, res_blk_next;
  logic [CNT_W-1:0]  res_added, res_added_next;
  logic              out_valid_next;
  logic [1:0]        status_next;
  logic [PAGE_W-1:0] block_pfn_next;
  logic [CNT_W-1:0]  pages_added_next, used_pages_next, total_pages_next;

  // helpers
  logic              found;
  logic [ORD_W-1:0]  fi;
  logic [ORD_W-1:0]  ck;
  logic [CNT_W:0]    csz;
  logic [CNT_W-1:0]  hi_in;
  logic [ORD_W-1:0]  hint_ord;

  // synchronous read, masked write
  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= page_mem[rd_addr];
    if (wr_en) begin
      if (wr_mask.kind) page_mem[wr_addr].kind <= wr_row.kind;
      if (wr_mask.mark) page_mem[wr_addr].mark <= wr_row.mark;
      if (wr_mask.link) page_mem[wr_addr].link <= wr_row.link;
      if (wr_mask.hint) page_mem[wr_addr].hint <= wr_row.hint;
    end
  end

  // first non-empty list at or above the requested order
  always_comb begin
    found = 1'b0;
    fi    = '0;
    for (int k = ORDERS - 1; k >= 0; k--) begin
      if (ORD_W'(k) >= order && heads[k] != NIL) begin
        found = 1'b1;
        fi    = ORD_W'(k);
      end
    end
  end

  // largest aligned block that fits at lo
  always_comb begin
    logic [CNT_W:0] sz;
    ck = '0;
    for (int k = 0; k < ORDERS; k++) begin
      sz = (CNT_W+1)'(1) << k;
      if ((({1'b0, lo} & (sz - 1'b1)) == '0) && ({1'b0, lo} + sz <= {1'b0, hi_q}))
        ck = ORD_W'(k);
    end
  end

  // size hint is a single set bit: encode it
  always_comb begin
    hint_ord = '0;
    for (int k = 0; k < ORDERS; k++) begin
      if (rd_q.hint[k]) hint_ord = ORD_W'(k);
    end
  end

  assign csz   = (CNT_W+1)'(1) << ck_q;
  assign hi_in = (range_end > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : range_end;
  assign in_ready = (state == S_IDLE);

  // next state and datapath
  always_comb begin
    state_next       = state;
    ret_state_next   = ret_state;
    clr_next         = clr;
    heads_next       = heads;
    tails_next       = tails;
    used_cnt_next    = used_cnt;
    total_cnt_next   = total_cnt;
    ord_q_next       = ord_q;
    j_next           = j;
    co_next          = co;
    po_next          = po;
    ck_q_next        = ck_q;
    p_q_next         = p_q;
    pp_next          = pp;
    b_q_next         = b_q;
    b_link_next      = b_link;
    prev_next        = prev;
    wp_next          = wp;
    ptail_next       = ptail;
    lo_next          = lo;
    hi_q_next        = hi_q;
    fill_next        = fill;
    res_status_next  = res_status;
    res_blk_next     = res_blk;
    res_added_next   = res_added;
    out_valid_next   = out_valid && !out_ready;
    status_next      = status;
    block_pfn_next   = block_pfn;
    pages_added_next = pages_added;
    used_pages_next  = used_pages;
    total_pages_next = total_pages;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_mask = '0;
    wr_row  = '{kind: KIND_PHANTOM, mark: '0, link: NIL, hint: '0};

    case (state)
      // sweep the page memory to its reset contents
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_mask  = '{kind: 1'b1, mark: 1'b1, link: 1'b1, hint: 1'b1};
        clr_next = clr + 1'b1;
        if (clr == PAGE_W'(NUM_PAGES - 1)) state_next = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          res_blk_next   = '0;
          res_added_next = '0;
          case (cmd)
            CMD_ALLOC: begin
              if (order >= ORD_W'(ORDERS)) begin
                res_status_next = ST_INVALID;
                state_next      = S_DONE;
              end else if (!found) begin
                res_status_next = ST_NOFREE;
                state_next      = S_DONE;
              end else begin
                p_q_next   = heads[fi][PAGE_W-1:0];
                j_next     = fi;
                ord_q_next = order;
                rd_en      = 1'b1;
                rd_addr    = heads[fi][PAGE_W-1:0];
                state_next = S_ALLOC_RD;
              end
            end
            CMD_FREE: begin
              p_q_next   = pfn;
              rd_en      = 1'b1;
              rd_addr    = pfn;
              state_next = S_FREE_RD;
            end
            CMD_ADD: begin
              if ({1'b0, pfn} >= hi_in) begin
                res_status_next = ST_OK;
                state_next      = S_DONE;
              end else begin
                lo_next    = {1'b0, pfn};
                fill_next  = {1'b0, pfn};
                hi_q_next  = hi_in;
                rd_en      = 1'b1;
                rd_addr    = pfn;
                state_next = S_SCAN;
              end
            end
            default: begin
              res_status_next = ST_INVALID;
              state_next      = S_DONE;
            end
          endcase
        end
      end

      // take the head block and mark it allocated
      S_ALLOC_RD: begin
        heads_next[j] = rd_q.link;
        if (tails[j] == {1'b0, p_q}) tails_next[j] = NIL;
        wr_en         = 1'b1;
        wr_addr       = p_q;
        wr_mask       = '{kind: 1'b1, mark: 1'b1, link: 1'b1, hint: 1'b1};
        wr_row.kind   = KIND_USED;
        wr_row.hint   = ORDERS'(1) << ord_q;
        used_cnt_next = used_cnt + (CNT_W'(1) << ord_q);
        state_next    = S_SPLIT;
      end

      // hand the upper halves down
      S_SPLIT: begin
        if (j > ord_q) begin
          pp_next        = p_q + (PAGE_W'(1) << (j - 1'b1));
          po_next        = j - 1'b1;
          j_next         = j - 1'b1;
          ret_state_next = S_SPLIT;
          state_next     = S_PUSH_ROW;
        end else begin
          res_status_next = ST_OK;
          res_blk_next    = p_q;
          state_next      = S_DONE;
        end
      end

      S_FREE_RD: begin
        if (rd_q.kind != KIND_USED) begin
          res_status_next = ST_INVALID;
          state_next      = S_DONE;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = p_q;
          wr_mask     = '{kind: 1'b1, mark: 1'b0, link: 1'b0, hint: 1'b1};
          wr_row.kind = KIND_INNER;
          co_next     = hint_ord;
          used_cnt_next = (used_cnt >= CNT_W'(rd_q.hint)) ?
                          used_cnt - CNT_W'(rd_q.hint) : '0;
          res_status_next = ST_OK;
          state_next      = S_MERGE_CHK;
        end
      end

      // look at the buddy of the current block
      S_MERGE_CHK: begin
        if (co < ORD_W'(ORDERS - 1)) begin
          b_q_next   = p_q ^ (PAGE_W'(1) << co);
          rd_en      = 1'b1;
          rd_addr    = p_q ^ (PAGE_W'(1) << co);
          state_next = S_MERGE_RD;
        end else begin
          pp_next        = p_q;
          po_next        = co;
          ret_state_next = S_DONE;
          state_next     = S_PUSH_ROW;
        end
      end

      S_MERGE_RD: begin
        if (rd_q.kind == KIND_FREE && rd_q.mark == co) begin
          b_link_next = rd_q.link;
          prev_next   = NIL;
          wp_next     = heads[co];
          state_next  = S_WALK;
        end else begin
          pp_next        = p_q;
          po_next        = co;
          ret_state_next = S_DONE;
          state_next     = S_PUSH_ROW;
        end
      end

      // walk the list to find the buddy's predecessor
      S_WALK: begin
        if (wp == {1'b0, b_q} || wp == NIL) begin
          state_next = S_UNLINK_PREV;
        end else begin
          prev_next  = wp;
          rd_en      = 1'b1;
          rd_addr    = wp[PAGE_W-1:0];
          state_next = S_WALK_RD;
        end
      end

      S_WALK_RD: begin
        wp_next    = rd_q.link;
        state_next = S_WALK;
      end

      S_UNLINK_PREV: begin
        if (prev == NIL) begin
          heads_next[co] = b_link;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = prev[PAGE_W-1:0];
          wr_mask     = '{kind: 1'b0, mark: 1'b0, link: 1'b1, hint: 1'b0};
          wr_row.link = b_link;
        end
        if (tails[co] == {1'b0, b_q}) tails_next[co] = prev;
        state_next = S_UNLINK_BLK;
      end

      S_UNLINK_BLK: begin
        wr_en       = 1'b1;
        wr_addr     = b_q;
        wr_mask     = '{kind: 1'b1, mark: 1'b1, link: 1'b1, hint: 1'b0};
        wr_row.kind = KIND_INNER;
        p_q_next    = p_q & b_q;
        co_next     = co + 1'b1;
        state_next  = S_MERGE_CHK;
      end

      // check the range is unmanaged, one page a cycle
      S_SCAN: begin
        if (rd_q.kind != KIND_PHANTOM) begin
          res_status_next = ST_INVALID;
          state_next      = S_DONE;
        end else if (fill + 1'b1 >= hi_q) begin
          state_next = S_CARVE;
        end else begin
          fill_next = fill + 1'b1;
          rd_en     = 1'b1;
          rd_addr   = fill[PAGE_W-1:0] + 1'b1;
        end
      end

      S_CARVE: begin
        if (lo >= hi_q) begin
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end else begin
          ck_q_next  = ck;
          fill_next  = lo + 1'b1;
          state_next = S_FILL;
        end
      end

      // mark the inner pages, then push the block
      S_FILL: begin
        if ({1'b0, fill} < {1'b0, lo} + csz) begin
          wr_en       = 1'b1;
          wr_addr     = fill[PAGE_W-1:0];
          wr_mask     = '{kind: 1'b1, mark: 1'b0, link: 1'b0, hint: 1'b0};
          wr_row.kind = KIND_INNER;
          fill_next   = fill + 1'b1;
        end else begin
          pp_next        = lo[PAGE_W-1:0];
          po_next        = ck_q;
          ret_state_next = S_CARVE;
          total_cnt_next = total_cnt + csz[CNT_W-1:0];
          res_added_next = res_added + csz[CNT_W-1:0];
          lo_next        = lo + csz[CNT_W-1:0];
          state_next     = S_PUSH_ROW;
        end
      end

      // append block pp to list po
      S_PUSH_ROW: begin
        wr_en       = 1'b1;
        wr_addr     = pp;
        wr_mask     = '{kind: 1'b1, mark: 1'b1, link: 1'b1, hint: 1'b0};
        wr_row.kind = KIND_FREE;
        wr_row.mark = po;
        ptail_next      = tails[po];
        tails_next[po]  = {1'b0, pp};
        if (tails[po] == NIL) begin
          heads_next[po] = {1'b0, pp};
          state_next     = ret_state;
        end else begin
          state_next = S_PUSH_LINK;
        end
      end

      S_PUSH_LINK: begin
        wr_en       = 1'b1;
        wr_addr     = ptail[PAGE_W-1:0];
        wr_mask     = '{kind: 1'b0, mark: 1'b0, link: 1'b1, hint: 1'b0};
        wr_row.link = {1'b0, pp};
        state_next  = ret_state;
      end

      // load the result once the output stage is free
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          block_pfn_next   = res_blk;
          pages_added_next = res_added;
          used_pages_next  = used_cnt;
          total_pages_next = total_cnt;
          state_next       = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret_state <= S_DONE;
      clr       <= '0;
      used_cnt  <= '0;
      total_cnt <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < ORDERS; k++) begin
        heads[k] <= NIL;
        tails[k] <= NIL;
      end
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      clr       <= clr_next;
      used_cnt  <= used_cnt_next;
      total_cnt <= total_cnt_next;
      out_valid <= out_valid_next;
      heads     <= heads_next;
      tails     <= tails_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ord_q       <= ord_q_next;
    j           <= j_next;
    co          <= co_next;
    po          <= po_next;
    ck_q        <= ck_q_next;
    p_q         <= p_q_next;
    pp          <= pp_next;
    b_q         <= b_q_next;
    b_link      <= b_link_next;
    prev        <= prev_next;
    wp          <= wp_next;
    ptail       <= ptail_next;
    lo          <= lo_next;
    hi_q        <= hi_q_next;
    fill        <= fill_next;
    res_status  <= res_status_next;
    res_blk     <= res_blk_next;
    res_added   <= res_added_next;
    status      <= status_next;
    block_pfn   <= block_pfn_next;
    pages_added <= pages_added_next;
    used_pages  <= used_pages_next;
    total_pages <= total_pages_next;
  end

endmodule

// ----- bench/bpa_checker.sv -----
module bpa_checker
  import bpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        cmd,
  input  logic [3:0]        order,
  input  logic [PAGE_W-1:0] pfn,
  input  logic [CNT_W-1:0]  range_end,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        status,
  input  logic [PAGE_W-1:0] block_pfn,
  input  logic [CNT_W-1:0]  pages_added,
  input  logic [CNT_W-1:0]  used_pages,
  input  logic [CNT_W-1:0]  total_pages,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t           st;
    logic [PAGE_W-1:0] blk;
    logic [CNT_W-1:0]  added;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  total;
  } alloc_reply_t;

  // Mirror of the page memory and free lists
  page_kind_t pg_kind [NUM_PAGES];
  int         pg_mark [NUM_PAGES];
  int         pg_next [NUM_PAGES];
  int         pg_hint [NUM_PAGES];
  int         fl_head [ORDERS];
  int         fl_tail [ORDERS];
  int         fl_len  [ORDERS];
  int         managed_pages;
  int         allocated_pages;

  alloc_reply_t replies_due[$];

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      pg_kind[i] = KIND_PHANTOM;
      pg_mark[i] = 0;
      pg_next[i] = NUM_PAGES;
      pg_hint[i] = 0;
    end
    for (int i = 0; i < ORDERS; i++) begin
      fl_head[i] = NUM_PAGES;
      fl_tail[i] = NUM_PAGES;
      fl_len[i]  = 0;
    end
    managed_pages   = 0;
    allocated_pages = 0;
  end

  // Append a free block at the tail of its order's list
  function automatic void list_append(int p, int o);
    if (p >= NUM_PAGES || o >= ORDERS) return;
    pg_next[p] = NUM_PAGES;
    if (fl_tail[o] < NUM_PAGES) pg_next[fl_tail[o]] = p;
    else fl_head[o] = p;
    fl_tail[o] = p;
    fl_len[o]++;
    pg_kind[p] = KIND_FREE;
    pg_mark[p] = o;
  endfunction

  // Take a free block out of its list; it becomes an inner page
  function automatic void list_remove(int p);
    int o;
    int prev;
    int cur;
    int steps;
    if (p >= NUM_PAGES) return;
    o = pg_mark[p];
    if (o >= ORDERS) return;
    prev = NUM_PAGES;
    cur = fl_head[o];
    steps = 0;
    while (cur < NUM_PAGES && cur != p && steps < NUM_PAGES) begin
      prev = cur;
      cur = pg_next[cur];
      steps++;
    end
    if (cur != p) return;
    if (prev == NUM_PAGES) fl_head[o] = pg_next[p];
    else pg_next[prev] = pg_next[p];
    if (fl_tail[o] == p) fl_tail[o] = prev;
    if (fl_len[o] > 0) fl_len[o]--;
    pg_next[p] = NUM_PAGES;
    pg_kind[p] = KIND_INNER;
    pg_mark[p] = 0;
  endfunction

  function automatic status_t grant_block(int o, output int blk);
    int p;
    blk = 0;
    if (o >= ORDERS) return ST_INVALID;
    for (int i = o; i < ORDERS; i++) begin
      p = fl_head[i];
      if (p >= NUM_PAGES) continue;
      list_remove(p);
      for (int j = i; j > o; j--) list_append(p + (1 << (j - 1)), j - 1);
      pg_kind[p] = KIND_USED;
      pg_hint[p] = 1 << o;
      allocated_pages += 1 << o;
      blk = p;
      return ST_OK;
    end
    return ST_NOFREE;
  endfunction

  // Release each hinted piece and merge it with free buddies
  function automatic status_t release_block(int p);
    int bits;
    int blk;
    int cur;
    int co;
    int bud;
    if (p >= NUM_PAGES || pg_kind[p] != KIND_USED) return ST_INVALID;
    bits = pg_hint[p] & ((1 << ORDERS) - 1);
    pg_hint[p] = 0;
    pg_kind[p] = KIND_INNER;
    for (int o = 0; o < ORDERS; o++) begin
      if (!bits[o]) continue;
      blk = p + (bits & ((1 << o) - 1));
      if (blk >= NUM_PAGES) continue;
      pg_kind[blk] = KIND_INNER;
      cur = blk;
      co = o;
      while (co + 1 < ORDERS) begin
        bud = cur ^ (1 << co);
        if (bud >= NUM_PAGES) break;
        if (pg_kind[bud] != KIND_FREE || pg_mark[bud] != co) break;
        list_remove(bud);
        cur = cur & bud;
        co++;
      end
      list_append(cur, co);
    end
    allocated_pages = (allocated_pages >= bits) ? allocated_pages - bits : 0;
    return ST_OK;
  endfunction

  // Cover a page range with the largest aligned blocks that fit
  function automatic status_t take_range(int lo, int hi, output int added);
    int start;
    int sz;
    added = 0;
    if (hi > NUM_PAGES) hi = NUM_PAGES;
    if (lo >= hi) return ST_OK;
    for (int p = lo; p < hi; p++)
      if (pg_kind[p] != KIND_PHANTOM) return ST_INVALID;
    start = managed_pages;
    while (lo < hi) begin
      for (int i = ORDERS; i > 0; i--) begin
        sz = 1 << (i - 1);
        if (lo + sz > hi || (lo & (sz - 1)) != 0) continue;
        for (int p = lo + 1; p < lo + sz; p++) pg_kind[p] = KIND_INNER;
        list_append(lo, i - 1);
        managed_pages += sz;
        lo += sz;
        break;
      end
    end
    added = managed_pages - start;
    return ST_OK;
  endfunction

  function automatic alloc_reply_t predict_reply(logic [1:0] c, int o, int p, int e);
    alloc_reply_t r;
    int blk;
    int added;
    blk = 0;
    added = 0;
    case (c)
      CMD_ALLOC: r.st = grant_block(o, blk);
      CMD_FREE:  r.st = release_block(p);
      CMD_ADD:   r.st = take_range(p, e, added);
      default:   r.st = ST_INVALID;
    endcase
    r.blk   = blk[PAGE_W-1:0];
    r.added = added[CNT_W-1:0];
    r.used  = allocated_pages[CNT_W-1:0];
    r.total = managed_pages[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d, wanted %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    alloc_reply_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        replies_due.push_back(predict_reply(cmd, order, pfn, range_end));
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result, status", status, -1);
        end else begin
          want = replies_due.pop_front();
          if (status != want.st) report_mismatch("status", status, want.st);
          if (block_pfn != want.blk) report_mismatch("block_pfn", block_pfn, want.blk);
          if (pages_added != want.added)
            report_mismatch("pages_added", pages_added, want.added);
          if (used_pages != want.used) report_mismatch("used_pages", used_pages, want.used);
          if (total_pages != want.total)
            report_mismatch("total_pages", total_pages, want.total);
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS = 700;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int ADD_CEILING = 4000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        cmd;
  logic [3:0]        order;
  logic [PAGE_W-1:0] pfn;
  logic [CNT_W-1:0]  range_end;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [PAGE_W-1:0] block_pfn;
  logic [CNT_W-1:0]  pages_added;
  logic [CNT_W-1:0]  used_pages;
  logic [CNT_W-1:0]  total_pages;
  int                errors;
  int                pending;

  int          cycles;
  int          sent;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int          hold_left;
  int          stall_left;
  int          next_range;
  int          n_alloc, n_free, n_add, n_bad;
  logic [1:0]  cmds_sent[$];
  int          live_blocks[$];

  buddy_page_allocator_unit dut (.*);

  bpa_checker checker_i (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Track granted blocks so that frees mostly hit live allocations
  always @(posedge clk) begin
    logic [1:0] c;
    if (!rst) begin
      if (in_valid && in_ready) cmds_sent.push_back(cmd);
      if (out_valid && out_ready && cmds_sent.size() > 0) begin
        c = cmds_sent.pop_front();
        if (c == CMD_ALLOC && status == ST_OK) live_blocks.push_back(block_pfn);
      end
    end
  end

  // Receiver: random stalls, one long hold-off, none when quiet
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one command and hold it until the transfer
  task automatic send_cmd(logic [1:0] c, int o, int p, int e);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    order     <= o[3:0];
    pfn       <= p[PAGE_W-1:0];
    range_end <= e[CNT_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (c)
      CMD_ALLOC: n_alloc++;
      CMD_FREE:  n_free++;
      CMD_ADD:   n_add++;
      default:   n_bad++;
    endcase
    sent++;
  endtask

  // Grow the managed area, now and then by a whole aligned top-order block
  task automatic add_next_range();
    int lo;
    int len;
    int aligned;
    aligned = ((next_range + 1023) / 1024) * 1024;
    if ($urandom_range(0, 19) == 0 && aligned + 1024 <= ADD_CEILING) begin
      lo = aligned;
      len = 1024;
    end else begin
      lo = next_range + $urandom_range(0, 8);
      len = $urandom_range(1, 80);
    end
    if (lo + len > ADD_CEILING) len = ADD_CEILING - lo;
    send_cmd(CMD_ADD, 0, lo, lo + len);
    if (lo + len > next_range) next_range = lo + len;
  endtask

  task automatic random_cmd();
    int pick;
    int idx;
    int lo;
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 80 && live_blocks.size() == 0)) begin
      if ($urandom_range(0, 29) == 0) send_cmd(CMD_ALLOC, $urandom_range(11, 15), 0, 0);
      else if ($urandom_range(0, 3) == 0) send_cmd(CMD_ALLOC, $urandom_range(4, 10), 0, 0);
      else send_cmd(CMD_ALLOC, $urandom_range(0, 3), $urandom, $urandom);
    end else if (pick < 80) begin
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(CMD_FREE, $urandom, $urandom_range(0, 4095), 0);
      end else begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        send_cmd(CMD_FREE, 0, live_blocks[idx], 0);
        live_blocks.delete(idx);
      end
    end else if (pick < 95) begin
      if (next_range < ADD_CEILING - 8 && $urandom_range(0, 5) != 0) begin
        add_next_range();
      end else begin
        lo = $urandom_range(0, 4095);
        if ($urandom_range(0, 7) == 0) send_cmd(CMD_ADD, 0, lo, 8191);
        else send_cmd(CMD_ADD, 0, lo, lo + $urandom_range(0, 40));
      end
    end else begin
      send_cmd(2'd3, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_ALLOC;
    order = '0;
    pfn = '0;
    range_end = '0;
    out_ready = 1'b0;
    cycles = 0;
    sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    stall_left = 0;
    next_range = 100;
    n_alloc = 0;
    n_free = 0;
    n_add = 0;
    n_bad = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: invalid codes, empty pool, range edge cases, double free
    send_cmd(2'd3, 15, 4095, 8191);
    send_cmd(CMD_ALLOC, 0, 0, 0);
    send_cmd(CMD_ALLOC, 15, 0, 0);
    send_cmd(CMD_FREE, 0, 4095, 0);
    send_cmd(CMD_ADD, 0, 10, 5);
    send_cmd(CMD_ADD, 0, 0, 100);
    send_cmd(CMD_ADD, 0, 3, 5);
    send_cmd(CMD_ADD, 0, 4000, 8191);
    send_cmd(CMD_ALLOC, 10, 0, 0);
    send_cmd(CMD_ALLOC, 11, 0, 0);
    send_cmd(CMD_ALLOC, 6, 0, 0);
    send_cmd(CMD_FREE, 0, 0, 0);
    send_cmd(CMD_FREE, 0, 0, 0);
    send_cmd(CMD_FREE, 0, 4000, 0);
    for (int o = 0; o <= 6; o++) send_cmd(CMD_ALLOC, o, 0, 0);
    send_cmd(CMD_ADD, 0, 4095, 4096);

    // Random phase, with quiet windows and one long output hold-off
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      quiet = (i >= 200 && i < 280) || i >= 600;
      if (i == 320) hold_req = 1'b1;
      random_cmd();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d commands: %0d allocate, %0d free, %0d add range, %0d unknown",
             sent, n_alloc, n_free, n_add, n_bad);
    $display("Managed pages at end %0d, still allocated %0d, %0d cycles",
             total_pages, used_pages, cycles);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bpa_pkg.sv
rtl/core/buddy_page_allocator_unit.sv
bench/bpa_checker.sv
bench/testbench.sv
